FILE: rtl/core/pmfb_pkg.sv
// Shared constants, item types and controller interface types of the page framebuffer engine.
package pmfb_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam logic [2:0] OP_POINT = 3'd0;
  localparam logic [2:0] OP_BLIT  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [3:0] MAX_BITS = 4'd8;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic [2:0] operation;
    logic [8:0] column;
    logic [8:0] row;
    logic       color;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic pix_step;
    logic rd_issue;
    logic out_load;
  } pmfb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pix_done;
    logic sweep_last;
    logic out_free;
  } pmfb_sts_t;

endpackage

FILE: rtl/core/pmfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, and read port that holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rd_data = rdata_r;

endmodule

FILE: rtl/core/pmfb_datapath.sv
// Datapath: item registers, pixel read-modify-write pipeline, sweep counter and result register.
module pmfb_datapath import pmfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  pmfb_cmd_t cmd,
  output pmfb_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  logic [8:0]        col_r;
  logic [8:0]        row_r;
  logic [3:0]        cnt_r;
  logic [7:0]        pdata_r;
  logic [3:0]        k_r;
  logic              p_valid_r;
  logic              p_ok_r;
  logic              p_bit_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [ADDR_W-1:0] sweep_addr_r;
  logic [7:0]        fill_val_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [9:0]        col_k;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic              pix_more;
  logic [7:0]        mask;
  logic [7:0]        rd_data;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;

  // Address and screen check of the current pixel column
  assign col_k    = {1'b0, col_r} + {6'd0, k_r};
  assign pix_ok   = (col_k < 10'(COLUMNS)) && (row_r < 9'(ROWS));
  assign pix_addr = ADDR_W'(32'(row_r[8:3]) * COLUMNS + 32'(col_k));
  assign pix_more = (k_r < cnt_r);
  assign mask     = 8'h01 << row_r[2:0];

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r <= in_data.column;
      row_r <= in_data.row;
      if (in_data.operation == OP_POINT) begin
        cnt_r   <= 4'd1;
        pdata_r <= {7'd0, in_data.color};
      end else begin
        cnt_r   <= (in_data.bit_count > MAX_BITS) ? MAX_BITS : in_data.bit_count;
        pdata_r <= in_data.data_byte;
      end
    end
  end

  // Advance the pixel pipeline: read pixel k while writing pixel k-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= 4'd0;
      p_valid_r <= 1'b0;
    end else if (cmd.accept) begin
      k_r       <= 4'd0;
      p_valid_r <= 1'b0;
    end else if (cmd.pix_step) begin
      p_valid_r <= pix_more;
      if (pix_more) begin
        k_r <= k_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.pix_step && pix_more) || cmd.rd_issue) begin
      p_ok_r   <= pix_ok;
      p_bit_r  <= pdata_r[k_r[2:0]];
      p_addr_r <= pix_addr;
    end
  end

  // Sweep counter and fill value; reset starts a clearing pass with zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
      fill_val_r   <= BYTE_ZERO;
    end else begin
      if (cmd.accept && (in_data.operation == OP_CLEAR)) begin
        fill_val_r <= BYTE_ZERO;
      end else if (cmd.accept && (in_data.operation == OP_FILL)) begin
        fill_val_r <= BYTE_ONES;
      end
      if (cmd.sweep_step) begin
        sweep_addr_r <= sts.sweep_last ? '0 : sweep_addr_r + ADDR_W'(1);
      end
    end
  end

  // Frame store ports
  assign ram_we    = cmd.sweep_step || (cmd.pix_step && p_valid_r && p_ok_r);
  assign ram_waddr = cmd.sweep_step ? sweep_addr_r : p_addr_r;
  assign ram_wdata = cmd.sweep_step ? fill_val_r
                   : (p_bit_r ? (rd_data | mask) : (rd_data & ~mask));
  assign ram_re    = (cmd.pix_step && pix_more) || cmd.rd_issue;

  pmfb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (pix_addr),
    .rd_data (rd_data)
  );

  // Result register; hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.read_data    <= p_ok_r ? rd_data : BYTE_ZERO;
      out_data_r.out_of_range <= !p_ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.pix_done   = !pix_more && !p_valid_r;
  assign sts.sweep_last = (sweep_addr_r == ADDR_W'(DEPTH - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

FILE: rtl/core/pmfb_ctrl.sv
// Controller state machine: sequences item acceptance, pixel updates, sweeps and reads.
module pmfb_ctrl import pmfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] operation,
  input  pmfb_sts_t  sts,
  output pmfb_cmd_t  cmd,
  output logic       in_stall
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PIX   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (operation) inside
            OP_POINT, OP_BLIT: state_nxt = S_PIX;
            OP_CLEAR, OP_FILL: state_nxt = S_SWEEP;
            OP_READ:           state_nxt = S_READ;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_PIX: begin
        cmd.pix_step = 1'b1;
        if (sts.pix_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register; reset enters the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: rtl/core/page_mono_framebuffer_engine_top.sv
// Top level of the page-organised monochrome framebuffer engine.
// Holds a COLUMNS x (PAGES*8) one-bit image in one 1024-byte RAM, eight vertical pixels per
// byte. After reset the block runs a clearing pass with in_stall high. Items are
// taken one at a time: points and blits make each pixel a read-modify-write through the
// RAM's single read and write port, overlapped one pixel apart; clear and fill write one
// byte a cycle; a read waits as long as the previous result still sits in the output
// register. Only reads return a result; off-screen pixels are skipped and an off-screen
// read returns zero with out_of_range set.
module page_mono_framebuffer_engine_top import pmfb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  pmfb_cmd_t cmd;
  pmfb_sts_t sts;

  pmfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .operation (in_data.operation),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  pmfb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // At most one datapath command per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.sweep_step, cmd.pix_step, cmd.rd_issue, cmd.out_load}))
    else $error("pmfb: overlapping controller commands");

  // Never overwrite a result still waiting to be taken
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pmfb: result overwritten while stalled");

  // A new result only follows a load command
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("pmfb: result without a read");

endmodule
